### rtl/core/bezier_curve_tessellator_assert.svh
// ----------------------------------------------------------------------------
// Bezier curve tessellator assertion macros
// Concurrent checks; bodies collapse to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef BEZIER_CURVE_TESSELLATOR_ASSERT_SVH
`define BEZIER_CURVE_TESSELLATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BCT_ASSERT_IMPL(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("same-cycle check failed");
`define BCT_ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle check failed");
`else
`define BCT_ASSERT_IMPL(lbl, clk, rst, pre, post)
`define BCT_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

### rtl/core/bct_pkg.sv
// ----------------------------------------------------------------------------
// Bezier curve tessellator package
// Shared widths, reset values and inter-module structs.
// ----------------------------------------------------------------------------
package bct_pkg;

  localparam int COORD_WIDTH_DEF   = 16;
  localparam int FAC_FRAC_BITS_DEF = 16;

  localparam int SEG_W    = 7;
  localparam int IDX_W    = 6;
  localparam int REM_W    = SEG_W + 1;
  localparam int MAX_SEGS = 64;

  localparam logic [SEG_W-1:0] SEG_RESET = SEG_W'(8);

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             last;
    logic             cubic;
  } tag_t;

  typedef struct packed {
    logic active;
    logic issue_last;
  } seq_status_t;

endpackage

### rtl/core/bct_fac_div.sv
// ----------------------------------------------------------------------------
// Step divider
// Restoring division of 2^F by the divisor (the interval count), one quotient bit a cycle.
// ----------------------------------------------------------------------------
module bct_fac_div import bct_pkg::*; #(
  parameter int F = FAC_FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SEG_W-1:0] divisor,
  output logic             busy,
  output logic [F-1:0]     quot,
  output logic [SEG_W-1:0] rem_out
);

  localparam int CNT_W = $clog2(F + 2);

  logic [CNT_W-1:0] cnt;
  logic [REM_W-1:0] rem;
  logic [F:0]       q;
  logic [REM_W-1:0] trial;
  logic             fit;

  assign trial   = {rem[REM_W-2:0], (cnt == CNT_W'(F + 1))};
  assign fit     = trial >= {1'b0, divisor};
  assign quot    = q[F-1:0];
  assign rem_out = rem[SEG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(F + 1);
    end else if (busy) begin
      busy <= (cnt != CNT_W'(1));
      cnt  <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= '0;
    end else if (busy) begin
      rem <= fit ? (trial - {1'b0, divisor}) : trial;
      q   <= {q[F-1:0], fit};
    end
  end

endmodule

### rtl/core/bct_sequencer.sv
// ----------------------------------------------------------------------------
// Point sequencer
// Holds one curve and issues one point a cycle, while its output is not stalled, with its interpolation factor.
// ----------------------------------------------------------------------------
module bct_sequencer import bct_pkg::*; #(
  parameter int W = COORD_WIDTH_DEF,
  parameter int F = FAC_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 hold,
  input  logic [SEG_W-1:0]     n,
  input  logic [F-1:0]         q0,
  input  logic [SEG_W-1:0]     r0,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0][W-1:0]    pt_start,
  input  logic [1:0][W-1:0]    pt_end,
  input  logic [1:0][W-1:0]    pt_ca,
  input  logic [1:0][W-1:0]    pt_cb,
  input  logic                 cubic,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [F-1:0]         out_fac,
  output tag_t                 out_tag,
  output logic [5:0][W-1:0]    out_a,
  output logic [5:0][W-1:0]    out_b,
  output seq_status_t          status
);

  logic             active;
  logic [1:0][W-1:0] h_p0, h_p1, h_c0, h_c1;
  logic             h_cubic;
  logic [IDX_W-1:0] idx;
  logic [F-1:0]     q;
  logic [SEG_W-1:0] r;

  logic             out_ld;
  logic             issue;
  logic             last_now;
  logic             accept;
  logic [REM_W-1:0] r_sum;
  logic             wrap;
  logic [F-1:0]     q_next;
  logic [SEG_W-1:0] r_next;
  logic [SEG_W-1:0] d;

  assign d        = n + SEG_W'(1);
  assign out_ld   = !out_valid || out_ready;
  assign issue    = active && out_ld;
  assign last_now = (SEG_W'(idx) + SEG_W'(1)) == n;
  assign in_ready = !hold && (!active || (out_ld && last_now));
  assign accept   = in_valid && in_ready;
  assign r_sum    = {1'b0, r} + {1'b0, r0};
  assign wrap     = r_sum >= {1'b0, d};
  assign r_next   = wrap ? SEG_W'(r_sum - {1'b0, d}) : SEG_W'(r_sum);
  assign q_next   = F'({1'b0, q} + {1'b0, q0} + (F + 1)'(wrap));

  assign status.active     = active;
  assign status.issue_last = issue && last_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        active <= 1'b1;
      end else if (issue && last_now) begin
        active <= 1'b0;
      end
      if (out_ld) begin
        out_valid <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      h_p0    <= pt_start;
      h_p1    <= pt_end;
      h_c0    <= pt_ca;
      h_c1    <= pt_cb;
      h_cubic <= cubic;
      idx     <= '0;
      q       <= q0;
      r       <= r0;
    end else if (issue) begin
      idx <= idx + IDX_W'(1);
      q   <= q_next;
      r   <= r_next;
    end
    if (issue) begin
      out_fac       <= q;
      out_tag.index <= idx;
      out_tag.last  <= last_now;
      out_tag.cubic <= h_cubic;
      for (int c = 0; c < 2; c++) begin
        out_a[3*c]     <= h_p0[c];
        out_b[3*c]     <= h_c0[c];
        out_a[3*c + 1] <= h_c0[c];
        out_b[3*c + 1] <= h_cubic ? h_c1[c] : h_p1[c];
        out_a[3*c + 2] <= h_c1[c];
        out_b[3*c + 2] <= h_p1[c];
      end
    end
  end

endmodule

### rtl/core/bct_lerp_level.sv
// ----------------------------------------------------------------------------
// Interpolation level
// Three-stage lerp over parallel lanes: difference, multiply, add and clamp.
// ----------------------------------------------------------------------------
module bct_lerp_level import bct_pkg::*; #(
  parameter int W  = COORD_WIDTH_DEF,
  parameter int F  = FAC_FRAC_BITS_DEF,
  parameter int NL = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [F-1:0]        in_fac,
  input  tag_t                in_tag,
  input  logic [NL-1:0][W-1:0] in_a,
  input  logic [NL-1:0][W-1:0] in_b,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [F-1:0]        out_fac,
  output tag_t                out_tag,
  output logic [NL-1:0][W-1:0] out_r
);

  logic v0, v1;
  logic rdy0, rdy1, rdy2;
  logic [F-1:0] fac0, fac1;
  tag_t         tag0, tag1;
  logic [NL-1:0][W-1:0]     a0, a1;
  logic [NL-1:0][W:0]       d0;
  logic [NL-1:0][W+F+1:0]   p1;

  assign rdy2     = !out_valid || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign rdy0     = !v0 || rdy1;
  assign in_ready = rdy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy0) begin
        v0 <= in_valid;
      end
      if (rdy1) begin
        v1 <= v0;
      end
      if (rdy2) begin
        out_valid <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      fac0 <= in_fac;
      tag0 <= in_tag;
      a0   <= in_a;
    end
    if (rdy1) begin
      fac1 <= fac0;
      tag1 <= tag0;
      a1   <= a0;
    end
    if (rdy2) begin
      out_fac <= fac1;
      out_tag <= tag1;
    end
  end

  for (genvar k = 0; k < NL; k++) begin : g_lane
    logic signed [W:0]     diff;
    logic signed [W+F+1:0] prod;
    logic signed [W+1:0]   step;
    logic signed [W+1:0]   sum;
    logic signed [W+1:0]   hi;
    logic signed [W+1:0]   lo;
    logic [W-1:0]          clamped;

    assign diff = $signed({in_b[k][W-1], in_b[k]}) - $signed({in_a[k][W-1], in_a[k]});
    assign prod = $signed(d0[k]) * $signed({1'b0, fac0});
    assign step = $signed(p1[k][W+F+1:F]);
    assign sum  = $signed({{2{a1[k][W-1]}}, a1[k]}) + step;
    assign hi   = $signed({3'b000, {(W-1){1'b1}}});
    assign lo   = $signed({3'b111, {(W-1){1'b0}}});

    always_comb begin
      if (sum > hi) begin
        clamped = hi[W-1:0];
      end else if (sum < lo) begin
        clamped = lo[W-1:0];
      end else begin
        clamped = sum[W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy0) begin
        d0[k] <= diff;
      end
      if (rdy1) begin
        p1[k] <= prod;
      end
      if (rdy2) begin
        out_r[k] <= clamped;
      end
    end
  end

endmodule

### rtl/core/bezier_curve_tessellator.sv
// ----------------------------------------------------------------------------
// Bezier curve tessellator
// Quadratic or cubic curve in, segment_count interior points out (zero as one,
// capped at MAX_SEGS) by de Casteljau evaluation over three pipelined lerp levels.
// ----------------------------------------------------------------------------
// Each curve is registered in the sequencer; its points pass the sequencer output
// register and the three lerp levels, one point per cycle while point_stall is
// low. A curve holds the input until its last point issues, and the next curve is
// taken in the cycle of that last issue. The step divider runs after reset and
// after each segment_count write, with curve input stalled meanwhile.
// Reset: synchronous; clears valids, sequencer and divider, segment_count = 8.
`include "bezier_curve_tessellator_assert.svh"

module bezier_curve_tessellator import bct_pkg::*; #(
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
  parameter int FAC_FRAC_BITS = FAC_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [SEG_W-1:0]       segment_count,
  input  logic                   curve_valid,
  output logic                   curve_stall,
  input  logic [COORD_WIDTH-1:0] start_x,
  input  logic [COORD_WIDTH-1:0] start_y,
  input  logic [COORD_WIDTH-1:0] end_x,
  input  logic [COORD_WIDTH-1:0] end_y,
  input  logic [COORD_WIDTH-1:0] ctrl_a_x,
  input  logic [COORD_WIDTH-1:0] ctrl_a_y,
  input  logic [COORD_WIDTH-1:0] ctrl_b_x,
  input  logic [COORD_WIDTH-1:0] ctrl_b_y,
  input  logic                   is_cubic,
  output logic                   point_valid,
  input  logic                   point_stall,
  output logic [COORD_WIDTH-1:0] point_x,
  output logic [COORD_WIDTH-1:0] point_y,
  output logic [IDX_W-1:0]       point_index,
  output logic                   last_point
);

  localparam int W = COORD_WIDTH;
  localparam int F = FAC_FRAC_BITS;

  logic [SEG_W-1:0] seg_count;
  logic [SEG_W-1:0] n_eff;
  logic             div_pending;
  logic             div_busy;
  logic [F-1:0]     q0;
  logic [SEG_W-1:0] r0;
  logic             seq_in_ready;
  seq_status_t      seq_st;

  logic             s_valid, s_ready;
  logic [F-1:0]     s_fac;
  tag_t             s_tag;
  logic [5:0][W-1:0] s_a, s_b;

  logic             l1_valid, l1_ready;
  logic [F-1:0]     l1_fac;
  tag_t             l1_tag;
  logic [5:0][W-1:0] l1_r;
  logic [3:0][W-1:0] l2_a, l2_b;

  logic             l2_valid, l2_ready;
  logic [F-1:0]     l2_fac;
  logic [F-1:0]     l3_fac;
  tag_t             l2_tag;
  logic [3:0][W-1:0] l2_r;
  logic [1:0][W-1:0] l3_a, l3_b;

  tag_t             l3_tag;
  logic [1:0][W-1:0] l3_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_count   <= SEG_RESET;
      div_pending <= 1'b1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        seg_count   <= segment_count;
        div_pending <= 1'b1;
      end else begin
        div_pending <= 1'b0;
      end
    end
  end

  always_comb begin
    if (seg_count == '0) begin
      n_eff = SEG_W'(1);
    end else if (seg_count > SEG_W'(MAX_SEGS)) begin
      n_eff = SEG_W'(MAX_SEGS);
    end else begin
      n_eff = seg_count;
    end
  end

  bct_fac_div #(.F(F)) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_pending),
    .divisor (n_eff + SEG_W'(1)),
    .busy    (div_busy),
    .quot    (q0),
    .rem_out (r0)
  );

  bct_sequencer #(.W(W), .F(F)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .hold      (div_pending || div_busy),
    .n         (n_eff),
    .q0        (q0),
    .r0        (r0),
    .in_valid  (curve_valid),
    .in_ready  (seq_in_ready),
    .pt_start  ({start_y, start_x}),
    .pt_end    ({end_y, end_x}),
    .pt_ca     ({ctrl_a_y, ctrl_a_x}),
    .pt_cb     ({ctrl_b_y, ctrl_b_x}),
    .cubic     (is_cubic),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_fac   (s_fac),
    .out_tag   (s_tag),
    .out_a     (s_a),
    .out_b     (s_b),
    .status    (seq_st)
  );

  assign curve_stall = !seq_in_ready;

  bct_lerp_level #(.W(W), .F(F), .NL(6)) u_lvl1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .in_fac    (s_fac),
    .in_tag    (s_tag),
    .in_a      (s_a),
    .in_b      (s_b),
    .out_valid (l1_valid),
    .out_ready (l1_ready),
    .out_fac   (l1_fac),
    .out_tag   (l1_tag),
    .out_r     (l1_r)
  );

  assign l2_a = {l1_r[4], l1_r[3], l1_r[1], l1_r[0]};
  assign l2_b = {l1_r[5], l1_r[4], l1_r[2], l1_r[1]};

  bct_lerp_level #(.W(W), .F(F), .NL(4)) u_lvl2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (l1_valid),
    .in_ready  (l1_ready),
    .in_fac    (l1_fac),
    .in_tag    (l1_tag),
    .in_a      (l2_a),
    .in_b      (l2_b),
    .out_valid (l2_valid),
    .out_ready (l2_ready),
    .out_fac   (l2_fac),
    .out_tag   (l2_tag),
    .out_r     (l2_r)
  );

  assign l3_a   = {l2_r[2], l2_r[0]};
  assign l3_b   = {l2_r[3], l2_r[1]};
  assign l3_fac = l2_tag.cubic ? l2_fac : '0;

  bct_lerp_level #(.W(W), .F(F), .NL(2)) u_lvl3 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (l2_valid),
    .in_ready  (l2_ready),
    .in_fac    (l3_fac),
    .in_tag    (l2_tag),
    .in_a      (l3_a),
    .in_b      (l3_b),
    .out_valid (point_valid),
    .out_ready (!point_stall),
    .out_fac   (),
    .out_tag   (l3_tag),
    .out_r     (l3_r)
  );

  assign point_x     = l3_r[0];
  assign point_y     = l3_r[1];
  assign point_index = l3_tag.index;
  assign last_point  = l3_tag.last;

  `BCT_ASSERT_NEXT(a_accept_arms_seq, clk, rst, curve_valid && !curve_stall, seq_st.active)
  `BCT_ASSERT_IMPL(a_seq_ends_on_last, clk, rst, $fell(seq_st.active), $past(seq_st.issue_last))

endmodule

### tb/sv/bezier_point_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bezier curve tessellator point checker
// Watches the configuration, curve and point channels. Each accepted curve is
// evaluated by de Casteljau interpolation at the current segment count, and
// every point transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bezier_point_checker import bct_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [SEG_W-1:0]           segment_count,
  input  logic                       curve_valid,
  input  logic                       curve_stall,
  input  logic [COORD_WIDTH_DEF-1:0] start_x,
  input  logic [COORD_WIDTH_DEF-1:0] start_y,
  input  logic [COORD_WIDTH_DEF-1:0] end_x,
  input  logic [COORD_WIDTH_DEF-1:0] end_y,
  input  logic [COORD_WIDTH_DEF-1:0] ctrl_a_x,
  input  logic [COORD_WIDTH_DEF-1:0] ctrl_a_y,
  input  logic [COORD_WIDTH_DEF-1:0] ctrl_b_x,
  input  logic [COORD_WIDTH_DEF-1:0] ctrl_b_y,
  input  logic                       is_cubic,
  input  logic                       point_valid,
  input  logic                       point_stall,
  input  logic [COORD_WIDTH_DEF-1:0] point_x,
  input  logic [COORD_WIDTH_DEF-1:0] point_y,
  input  logic [IDX_W-1:0]           point_index,
  input  logic                       last_point,
  output int                         mismatches,
  output int                         outstanding
);

  localparam int     CW        = COORD_WIDTH_DEF;
  localparam int     FRAC      = FAC_FRAC_BITS_DEF;
  localparam longint COORD_MAX = (longint'(1) <<< (CW - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;

  typedef struct packed {
    logic [CW-1:0]    x;
    logic [CW-1:0]    y;
    logic [IDX_W-1:0] index;
    logic             last;
  } curve_point_t;

  curve_point_t     expected_points[$];
  logic [SEG_W-1:0] seg_setting = SEG_RESET;
  int               error_total = 0;

  assign mismatches = error_total;

  function automatic longint lerp_q(input longint a, input longint b, input longint fac);
    return a + (((b - a) * fac) >>> FRAC);
  endfunction

  function automatic logic [CW-1:0] curve_coord(input logic [CW-1:0] p0, c0, c1, p1,
                                                input logic cubic, input longint fac);
    longint a, b, c, d, r0, r1, r2, v;
    a = longint'($signed(p0));
    b = longint'($signed(c0));
    c = longint'($signed(c1));
    d = longint'($signed(p1));
    if (cubic) begin
      r0 = lerp_q(a, b, fac);
      r1 = lerp_q(b, c, fac);
      r2 = lerp_q(c, d, fac);
      v  = lerp_q(lerp_q(r0, r1, fac), lerp_q(r1, r2, fac), fac);
    end else begin
      v = lerp_q(lerp_q(a, b, fac), lerp_q(b, d, fac), fac);
    end
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return v[CW-1:0];
  endfunction

  task automatic predict_curve_points();
    int           n;
    longint       fac;
    curve_point_t pt;
    n = int'(seg_setting);
    if (n == 0) n = 1;
    if (n > MAX_SEGS) n = MAX_SEGS;
    for (int i = 0; i < n; i++) begin
      fac      = (longint'(i + 1) <<< FRAC) / longint'(n + 1);
      pt.x     = curve_coord(start_x, ctrl_a_x, ctrl_b_x, end_x, is_cubic, fac);
      pt.y     = curve_coord(start_y, ctrl_a_y, ctrl_b_y, end_y, is_cubic, fac);
      pt.index = IDX_W'(i);
      pt.last  = (i == n - 1);
      expected_points.push_back(pt);
    end
  endtask

  task automatic compare_point();
    curve_point_t want;
    if (expected_points.size() == 0) begin
      error_total++;
      if (error_total <= 10)
        $display("%0t: unexpected point x=%h y=%h index=%0d last=%0b",
                 $time, point_x, point_y, point_index, last_point);
    end else begin
      want = expected_points.pop_front();
      if (want.x !== point_x || want.y !== point_y || want.index !== point_index ||
          want.last !== last_point) begin
        error_total++;
        if (error_total <= 10)
          $display("%0t: point mismatch, expected x=%h y=%h index=%0d last=%0b, got x=%h y=%h index=%0d last=%0b",
                   $time, want.x, want.y, want.index, want.last,
                   point_x, point_y, point_index, last_point);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      seg_setting = SEG_RESET;
      expected_points.delete();
    end else begin
      if (cfg_valid && cfg_ready) seg_setting = segment_count;
      if (curve_valid && !curve_stall) predict_curve_points();
      if (point_valid && !point_stall) compare_point();
    end
    outstanding <= expected_points.size();
  end

endmodule

### tb/sv/tb_bezier_curve_tessellator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bezier curve tessellator testbench
// Sends directed corner curves and then random quadratic and cubic curves
// across a series of segment counts, including zero and counts above the
// maximum, with random gaps on the curve side and random point stalls. A
// separate checker predicts and compares every point.
// ----------------------------------------------------------------------------
module tb_bezier_curve_tessellator;
  import bct_pkg::*;

  localparam int CW             = COORD_WIDTH_DEF;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_CURVES   = 28;

  typedef struct packed {
    logic [CW-1:0] sx, sy, ex, ey, ax, ay, bx, by;
    logic          cubic;
  } curve_t;

  logic             clk;
  logic             rst;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [SEG_W-1:0] segment_count;
  logic             curve_valid;
  logic             curve_stall;
  logic [CW-1:0]    start_x, start_y, end_x, end_y;
  logic [CW-1:0]    ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y;
  logic             is_cubic;
  logic             point_valid;
  logic             point_stall;
  logic [CW-1:0]    point_x, point_y;
  logic [IDX_W-1:0] point_index;
  logic             last_point;

  int mismatches;
  int outstanding;
  int quiet_cycles = 0;
  int stall_left   = 0;
  bit steady_sender;

  bezier_curve_tessellator dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .segment_count(segment_count),
    .curve_valid  (curve_valid),
    .curve_stall  (curve_stall),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .ctrl_a_x     (ctrl_a_x),
    .ctrl_a_y     (ctrl_a_y),
    .ctrl_b_x     (ctrl_b_x),
    .ctrl_b_y     (ctrl_b_y),
    .is_cubic     (is_cubic),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_index  (point_index),
    .last_point   (last_point)
  );

  bezier_point_checker point_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .segment_count(segment_count),
    .curve_valid  (curve_valid),
    .curve_stall  (curve_stall),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .ctrl_a_x     (ctrl_a_x),
    .ctrl_a_y     (ctrl_a_y),
    .ctrl_b_x     (ctrl_b_x),
    .ctrl_b_y     (ctrl_b_y),
    .is_cubic     (is_cubic),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_index  (point_index),
    .last_point   (last_point),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic curve_t make_curve(input logic [CW-1:0] sx, sy, ex, ey, ax, ay, bx, by,
                                        input logic cubic);
    return '{sx, sy, ex, ey, ax, ay, bx, by, cubic};
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7FFF;
    if (r == 2) return CW'($urandom_range(0, 64) - 32);
    return CW'($urandom());
  endfunction

  function automatic curve_t rand_curve();
    return make_curve(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      1'($urandom_range(0, 1)));
  endfunction

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_sender || r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [SEG_W-1:0] pick_segment_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return SEG_W'($urandom_range(1, 12));
    if (r < 80) return SEG_W'($urandom_range(13, 40));
    if (r < 88) return SEG_W'($urandom_range(64, 127));
    if (r < 94) return '0;
    return SEG_W'($urandom_range(41, 63));
  endfunction

  task automatic send_curve(input curve_t c);
    curve_valid <= 1'b1;
    {start_x, start_y, end_x, end_y, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y, is_cubic} <= c;
    do @(posedge clk); while (curve_stall);
  endtask

  task automatic hold_sender(input int cycles);
    if (cycles > 0) begin
      curve_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    curve_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_segment_count(input logic [SEG_W-1:0] value);
    wait_for_drain();
    cfg_valid     <= 1'b1;
    segment_count <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_and_gap(input curve_t c);
    send_curve(c);
    hold_sender(sender_gap());
  endtask

  // point side: alternate stall and free stretches, mostly short
  always @(posedge clk) begin
    if (rst) begin
      point_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if (point_stall) begin
      point_stall <= 1'b0;
      stall_left = ($urandom_range(0, 99) < 20) ? $urandom_range(60, 200)
                                                : $urandom_range(0, 6);
    end else begin
      point_stall <= 1'b1;
      case ($urandom_range(0, 9))
        0:       stall_left = $urandom_range(15, 50);
        1, 2:    stall_left = $urandom_range(1, 4);
        default: stall_left = 0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (curve_valid && !curve_stall) ||
        (point_valid && !point_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    steady_sender = 1'b0;
    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    segment_count <= '0;
    curve_valid   <= 1'b0;
    {start_x, start_y, end_x, end_y} <= '0;
    {ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y} <= '0;
    is_cubic      <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset segment count
    send_and_gap(make_curve('0, '0, '0, '0, '0, '0, '0, '0, 1'b0));
    send_and_gap(make_curve('0, '0, '0, '0, '0, '0, '0, '0, 1'b1));
    send_and_gap(make_curve(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                            16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0));
    send_and_gap(make_curve(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                            16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1));
    send_and_gap(make_curve(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                            16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0));
    send_and_gap(make_curve(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                            16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1));
    send_and_gap(make_curve(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
                            16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 1'b1));
    send_and_gap(make_curve(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
                            16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 1'b0));
    send_and_gap(make_curve(16'h1234, 16'hEDCC, 16'h0F00, 16'hF100,
                            16'h0800, 16'hF800, 16'h7FFF, 16'h8000, 1'b0));
    send_and_gap(make_curve(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555,
                            16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 1'b1));
    send_and_gap(make_curve(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA,
                            16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 1'b0));
    send_and_gap(make_curve(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                            '0, '0, '0, '0, 1'b1));

    // zero count acts as one point
    write_segment_count('0);
    send_and_gap(make_curve(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                            16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 1'b1));
    send_and_gap(make_curve(16'h7FFF, 16'h0001, 16'hFFFF, 16'h8000,
                            16'h8000, 16'h7FFF, 16'h1111, 16'h2222, 1'b0));

    // counts above the maximum saturate; the maximum and a count of one follow
    write_segment_count(SEG_W'(127));
    send_and_gap(make_curve(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
                            16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 1'b1));
    write_segment_count(SEG_W'(MAX_SEGS));
    send_and_gap(make_curve(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                            16'h7FFF, 16'h8000, '0, '0, 1'b0));
    write_segment_count(SEG_W'(MAX_SEGS + 1));
    send_and_gap(make_curve(16'h4000, 16'hC000, 16'hC000, 16'h4000,
                            16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 1'b1));
    write_segment_count(SEG_W'(1));
    send_and_gap(make_curve(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
                            16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b1));
    send_and_gap(make_curve(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
                            16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b0));

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_segment_count(pick_segment_count());
      steady_sender = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PHASE_CURVES; k++) begin
        send_curve(rand_curve());
        if (k == PHASE_CURVES / 2 && phase % 3 == 1) wait_for_drain();
        else hold_sender(sender_gap());
      end
    end

    wait_for_drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/bct_pkg.sv
rtl/core/bct_fac_div.sv
rtl/core/bct_sequencer.sv
rtl/core/bct_lerp_level.sv
rtl/core/bezier_curve_tessellator.sv
tb/sv/bezier_point_checker.sv
tb/sv/tb_bezier_curve_tessellator.sv
